@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, ignored while reset is low.
`define SRT_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("srt assertion failed");

// Same-cycle implication from a condition to a consequence.
`define SRT_IMPLIES(lbl, ck, rn, cond, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (cons)) \
		else $error("srt implication failed");

`endif

@@ rtl/srt_pkg.sv @@
// Package with widths, register codes and types of the stereo triangulation block.
`timescale 1ns / 1ps
package srt_pkg;

	// Pixel and output coordinate widths.
	localparam int PIXEL_BITS = 10;
	localparam int COORD_BITS = 24;

	// Configuration port.
	localparam int CFG_W = 16;
	localparam int IDX_W = 3;
	typedef enum logic [IDX_W-1:0] {
		CFG_BASELINE = 3'd0,
		CFG_TAN_X    = 3'd1,
		CFG_TAN_Y    = 3'd2,
		CFG_CENTRE_X = 3'd3,
		CFG_CENTRE_Y = 3'd4
	} cfg_idx_t;

	localparam int TAN_W  = 16;
	localparam int BASE_W = 16;
	localparam int LANES  = 4;

	// Direction division: quotient bits and clip level.
	localparam int FRAC_DIR = 17;
	localparam int DPROD_W  = PIXEL_BITS + TAN_W;
	localparam int DIR_W    = FRAC_DIR + 1;
	localparam logic [FRAC_DIR-1:0] DIR_LIM = '1;

	// Cross product and closest approach terms.
	localparam int NX_W  = DIR_W + 1;
	localparam int PUV_W = 2 * DIR_W;
	localparam int T_W   = PUV_W + 1;
	localparam int NZ_W  = 21;
	localparam int SQ_W  = 2 * NX_W;
	localparam int NZSQ_W = 2 * NZ_W;
	localparam int DEN_W = 40;
	localparam int QP_W  = DIR_W + NZ_W;
	localparam int QL_W  = 40;
	localparam int QM_W  = QL_W - 1;
	localparam int QLO_W = 20;
	localparam int QHI_W = QM_W - QLO_W;
	localparam int NUM_W = BASE_W + QM_W;

	// Depth values, clipped to plus or minus 2^DEPTH_SH.
	localparam int DEPTH_SH = 40;
	localparam int Z_W   = DEPTH_SH + 2;
	localparam int ZLO_W = 24;
	localparam int ZHI_W = Z_W - ZLO_W;
	localparam int PLO_W = DIR_W + ZLO_W + 1;
	localparam int PHI_W = DIR_W + ZHI_W;
	localparam int M_W   = 60;
	localparam int MID_SH = 17;
	localparam int MID_W = M_W - MID_SH;

	// Side data that travels with each item through the depth divider.
	typedef struct packed {
		logic signed [DIR_W-1:0] ul;
		logic signed [DIR_W-1:0] vl;
		logic signed [DIR_W-1:0] ur;
		logic signed [DIR_W-1:0] vr;
		logic                    hit;
		logic                    neg_l;
		logic                    neg_r;
		logic                    par;
	} srt_side_t;

endpackage

@@ rtl/srt_pix_if.sv @@
// Input channel interface: one pixel pair from the two cameras per beat.
`timescale 1ns / 1ps
interface srt_pix_if;
	logic valid;
	logic ready;
	logic [srt_pkg::PIXEL_BITS-1:0] left_px_x;
	logic [srt_pkg::PIXEL_BITS-1:0] left_px_y;
	logic [srt_pkg::PIXEL_BITS-1:0] right_px_x;
	logic [srt_pkg::PIXEL_BITS-1:0] right_px_y;

	modport source(output valid, left_px_x, left_px_y, right_px_x, right_px_y, input ready);
	modport sink(input valid, left_px_x, left_px_y, right_px_x, right_px_y, output ready);
endinterface

@@ rtl/srt_mid_if.sv @@
// Output channel interface: one triangulated point per beat.
`timescale 1ns / 1ps
interface srt_mid_if;
	logic valid;
	logic ready;
	logic signed [srt_pkg::COORD_BITS-1:0] mid_x;
	logic signed [srt_pkg::COORD_BITS-1:0] mid_y;
	logic signed [srt_pkg::COORD_BITS-1:0] mid_z;
	logic rays_parallel;
	logic saturated;

	modport source(output valid, mid_x, mid_y, mid_z, rays_parallel, saturated, input ready);
	modport sink(input valid, mid_x, mid_y, mid_z, rays_parallel, saturated, output ready);
endinterface

@@ rtl/srt_zdiv.sv @@
// Pipelined restoring divider for the two ray depths, one quotient bit per stage.
`timescale 1ns / 1ps
module srt_zdiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [srt_pkg::NUM_W-1:0]      num_l,
	input  logic [srt_pkg::NUM_W-1:0]      num_r,
	input  logic [srt_pkg::DEN_W-1:0]      den,
	input  srt_pkg::srt_side_t             side_i,
	output logic                           out_valid,
	output logic [srt_pkg::NUM_W-1:0]      q_l,
	output logic [srt_pkg::NUM_W-1:0]      q_r,
	output srt_pkg::srt_side_t             side_o
);

	// Index 0 is the input; stage k writes index k+1.
	logic [srt_pkg::NUM_W-1:0] a_l_sd   [0:srt_pkg::NUM_W];
	logic [srt_pkg::NUM_W-1:0] a_r_sd   [0:srt_pkg::NUM_W];
	logic [srt_pkg::DEN_W-1:0] rem_l_sd [0:srt_pkg::NUM_W];
	logic [srt_pkg::DEN_W-1:0] rem_r_sd [0:srt_pkg::NUM_W];
	logic [srt_pkg::DEN_W-1:0] den_sd   [0:srt_pkg::NUM_W];
	srt_pkg::srt_side_t        side_sd  [0:srt_pkg::NUM_W];
	logic [srt_pkg::NUM_W:0]   v_sd;

	assign a_l_sd[0]   = num_l;
	assign a_r_sd[0]   = num_r;
	assign rem_l_sd[0] = '0;
	assign rem_r_sd[0] = '0;
	assign den_sd[0]   = den;
	assign side_sd[0]  = side_i;
	assign v_sd[0]     = in_valid;

	for (genvar k = 0; k < srt_pkg::NUM_W; k++) begin : g_stg
		logic [srt_pkg::DEN_W:0] r2_l;
		logic [srt_pkg::DEN_W:0] r2_r;
		logic                    ge_l;
		logic                    ge_r;

		// Shift in the next numerator bit and try to subtract the divisor.
		assign r2_l = {rem_l_sd[k], a_l_sd[k][srt_pkg::NUM_W-1]};
		assign r2_r = {rem_r_sd[k], a_r_sd[k][srt_pkg::NUM_W-1]};
		assign ge_l = r2_l >= {1'b0, den_sd[k]};
		assign ge_r = r2_r >= {1'b0, den_sd[k]};

		// The numerator register fills with quotient bits from the bottom.
		always_ff @(posedge clk) begin
			if (en) begin
				rem_l_sd[k+1] <= ge_l ? srt_pkg::DEN_W'(r2_l - {1'b0, den_sd[k]})
					: r2_l[srt_pkg::DEN_W-1:0];
				rem_r_sd[k+1] <= ge_r ? srt_pkg::DEN_W'(r2_r - {1'b0, den_sd[k]})
					: r2_r[srt_pkg::DEN_W-1:0];
				a_l_sd[k+1]   <= {a_l_sd[k][srt_pkg::NUM_W-2:0], ge_l};
				a_r_sd[k+1]   <= {a_r_sd[k][srt_pkg::NUM_W-2:0], ge_r};
				den_sd[k+1]   <= den_sd[k];
				side_sd[k+1]  <= side_sd[k];
			end
		end

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (en) begin
				v_sd[k+1] <= v_sd[k];
			end
		end
	end

	assign out_valid = v_sd[srt_pkg::NUM_W];
	assign q_l       = a_l_sd[srt_pkg::NUM_W];
	assign q_r       = a_r_sd[srt_pkg::NUM_W];
	assign side_o    = side_sd[srt_pkg::NUM_W];

endmodule

@@ rtl/stereo_ray_triangulation_top.sv @@
// Top level of the stereo ray triangulation pipeline.
//
// Channels: pix takes one beat with the blob position seen by the left and the
// right camera; mid returns one beat per input with the midpoint of closest
// approach of the two rays (x, y, z in centimetres Q8), a parallel-ray flag
// and a saturation flag. Results leave in input order.
// Configuration: cfg_we writes cfg_data into the register named by cfg_idx
// (baseline, two field-of-view tangents, two optical centre coordinates).
// Write it only while no beat is in flight.
// Throughput: one beat per cycle while no result waits on mid. The pipeline
// holds 17 bit stages of the direction divider and 55 bit stages of the depth
// divider; the rest are multiply and add stages.
// Reset: valid bits clear and configuration returns to its defaults; no
// clearing pass is needed.
// Stall: while a result waits on mid, the whole pipeline holds and pix.ready
// is low; nothing is lost or repeated. With mid empty, pix.ready is high.
`timescale 1ns / 1ps
module stereo_ray_triangulation_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [srt_pkg::IDX_W-1:0]      cfg_idx,
	input  logic [srt_pkg::CFG_W-1:0]      cfg_data,
	srt_pix_if.sink                        pix,
	srt_mid_if.source                      mid
);

	localparam int P = srt_pkg::PIXEL_BITS;
	localparam int FD = srt_pkg::FRAC_DIR;
	localparam int NL = srt_pkg::LANES;

	// Configuration registers.
	logic [srt_pkg::BASE_W-1:0] base_q;
	logic [srt_pkg::TAN_W-1:0]  tan_x_q;
	logic [srt_pkg::TAN_W-1:0]  tan_y_q;
	logic [P-1:0]               cx_q;
	logic [P-1:0]               cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= srt_pkg::BASE_W'(1024);
			tan_x_q <= srt_pkg::TAN_W'(19413);
			tan_y_q <= srt_pkg::TAN_W'(13333);
			cx_q    <= P'(512);
			cy_q    <= P'(375);
		end else if (cfg_we) begin
			case (srt_pkg::cfg_idx_t'(cfg_idx))
				srt_pkg::CFG_BASELINE: base_q  <= cfg_data[srt_pkg::BASE_W-1:0];
				srt_pkg::CFG_TAN_X:    tan_x_q <= cfg_data[srt_pkg::TAN_W-1:0];
				srt_pkg::CFG_TAN_Y:    tan_y_q <= cfg_data[srt_pkg::TAN_W-1:0];
				srt_pkg::CFG_CENTRE_X: cx_q    <= cfg_data[P-1:0];
				srt_pkg::CFG_CENTRE_Y: cy_q    <= cfg_data[P-1:0];
				default: begin
				end
			endcase
		end
	end

	// A zero centre acts as one; lanes are ul, vl, ur, vr.
	logic [P-1:0]               cen [NL];
	logic [srt_pkg::TAN_W-1:0]  tan [NL];
	logic [P-1:0]               px  [NL];

	always_comb begin
		cen[0] = (cx_q == '0) ? P'(1) : cx_q;
		cen[1] = (cy_q == '0) ? P'(1) : cy_q;
		cen[2] = cen[0];
		cen[3] = cen[1];
		tan[0] = tan_x_q;
		tan[1] = tan_y_q;
		tan[2] = tan_x_q;
		tan[3] = tan_y_q;
		px[0]  = pix.left_px_x;
		px[1]  = pix.left_px_y;
		px[2]  = pix.right_px_x;
		px[3]  = pix.right_px_y;
	end

	// The whole pipeline moves unless a result waits at the output.
	logic v_s15;
	logic en;

	assign en        = !v_s15 || mid.ready;
	assign pix.ready = en;

	// Stage 1: pixel offset from centre times the tangent, as sign and magnitude.
	logic [srt_pkg::DPROD_W-1:0] prod_s1 [NL];
	logic                        neg_s1  [NL];
	logic                        v_s1;

	// Direction divider pipeline; index 0 is stage 2.
	logic [P-1:0]  rem_sd  [0:FD][NL];
	logic [FD-1:0] low_sd  [0:FD][NL];
	logic [FD-1:0] q_sd    [0:FD][NL];
	logic          neg_sd  [0:FD][NL];
	logic          clip_sd [0:FD][NL];
	logic [FD:0]   vd_sd;

	for (genvar l = 0; l < NL; l++) begin : g_ln
		logic signed [P:0] diff;
		logic              dneg;
		logic [P-1:0]      dmag;

		assign diff = $signed({1'b0, px[l]}) - $signed({1'b0, cen[l]});
		assign dneg = diff[P];
		assign dmag = dneg ? P'(-diff) : diff[P-1:0];

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[l] <= srt_pkg::DPROD_W'(dmag * tan[l]);
				neg_s1[l]  <= dneg;
			end
		end

		// Stage 2: detect clipping and seed the remainder with the top bits.
		always_ff @(posedge clk) begin
			if (en) begin
				clip_sd[0][l] <= {1'b0, prod_s1[l]} >= {cen[l], FD'(0)};
				rem_sd[0][l]  <= P'(prod_s1[l][srt_pkg::DPROD_W-1:FD]);
				low_sd[0][l]  <= prod_s1[l][FD-1:0];
				q_sd[0][l]    <= '0;
				neg_sd[0][l]  <= neg_s1[l];
			end
		end

		// One quotient bit per stage.
		for (genvar k = 0; k < FD; k++) begin : g_dstg
			logic [P:0] r2;
			logic       ge;

			assign r2 = {rem_sd[k][l], low_sd[k][l][FD-1-k]};
			assign ge = r2 >= {1'b0, cen[l]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[k+1][l]  <= ge ? P'(r2 - {1'b0, cen[l]}) : r2[P-1:0];
					low_sd[k+1][l]  <= low_sd[k][l];
					q_sd[k+1][l]    <= {q_sd[k][l][FD-2:0], ge};
					neg_sd[k+1][l]  <= neg_sd[k][l];
					clip_sd[k+1][l] <= clip_sd[k][l];
				end
			end
		end
	end

	// Stage 3: signed, clipped ray directions.
	srt_pkg::srt_side_t side_s3;
	logic signed [srt_pkg::DIR_W-1:0] dir_c [NL];
	logic v_s3;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			dir_c[l] = clip_sd[FD][l] ? $signed({1'b0, srt_pkg::DIR_LIM})
				: $signed({1'b0, q_sd[FD][l]});
			if (neg_sd[FD][l]) begin
				dir_c[l] = -dir_c[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.ul    <= dir_c[0];
			side_s3.vl    <= dir_c[1];
			side_s3.ur    <= dir_c[2];
			side_s3.vr    <= dir_c[3];
			side_s3.hit   <= clip_sd[FD][0] | clip_sd[FD][1] | clip_sd[FD][2] | clip_sd[FD][3];
			side_s3.neg_l <= 1'b0;
			side_s3.neg_r <= 1'b0;
			side_s3.par   <= 1'b0;
		end
	end

	// Stage 4: in-plane cross terms and the two products of nz.
	srt_pkg::srt_side_t side_s4;
	logic signed [srt_pkg::NX_W-1:0]  nx_s4, ny_s4;
	logic signed [srt_pkg::PUV_W-1:0] p1_s4, p2_s4;
	logic v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			nx_s4   <= srt_pkg::NX_W'(side_s3.vl) - srt_pkg::NX_W'(side_s3.vr);
			ny_s4   <= srt_pkg::NX_W'(side_s3.ur) - srt_pkg::NX_W'(side_s3.ul);
			p1_s4   <= side_s3.ul * side_s3.vr;
			p2_s4   <= side_s3.vl * side_s3.ur;
		end
	end

	// Stage 5: nz truncated toward zero, and the squares of nx and ny.
	srt_pkg::srt_side_t side_s5;
	logic signed [srt_pkg::NX_W-1:0] ny_s5;
	logic signed [srt_pkg::NZ_W-1:0] nz_s5;
	logic signed [srt_pkg::SQ_W-1:0] nx2_s5, ny2_s5;
	logic signed [srt_pkg::T_W-1:0]  t_c, tsh_c;
	logic                            trnd_c;
	logic v_s5;

	assign t_c    = srt_pkg::T_W'(p1_s4) - srt_pkg::T_W'(p2_s4);
	assign tsh_c  = t_c >>> 16;
	assign trnd_c = t_c[srt_pkg::T_W-1] && (t_c[15:0] != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			ny_s5   <= ny_s4;
			nz_s5   <= srt_pkg::NZ_W'(tsh_c) + srt_pkg::NZ_W'(trnd_c);
			nx2_s5  <= nx_s4 * nx_s4;
			ny2_s5  <= ny_s4 * ny_s4;
		end
	end

	// Stage 6: nz squared and the direction-times-nz products.
	srt_pkg::srt_side_t side_s6;
	logic signed [srt_pkg::NX_W-1:0]   ny_s6;
	logic signed [srt_pkg::SQ_W-1:0]   nx2_s6, ny2_s6;
	logic signed [srt_pkg::NZSQ_W-1:0] nz2_s6;
	logic signed [srt_pkg::QP_W-1:0]   vrnz_s6, vlnz_s6;
	logic v_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			ny_s6   <= ny_s5;
			nx2_s6  <= nx2_s5;
			ny2_s6  <= ny2_s5;
			nz2_s6  <= nz_s5 * nz_s5;
			vrnz_s6 <= side_s5.vr * nz_s5;
			vlnz_s6 <= side_s5.vl * nz_s5;
		end
	end

	// Stage 7: denominator and the two closest-approach numerators.
	srt_pkg::srt_side_t side_s7;
	logic [srt_pkg::DEN_W-1:0]       den_s7;
	logic signed [srt_pkg::QL_W-1:0] ql_s7, qr_s7;
	logic signed [srt_pkg::QL_W-1:0] nysh_c;
	logic v_s7;

	assign nysh_c = srt_pkg::QL_W'(ny_s6) <<< 16;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			den_s7  <= srt_pkg::DEN_W'($unsigned(nx2_s6)) + srt_pkg::DEN_W'($unsigned(ny2_s6))
				+ srt_pkg::DEN_W'($unsigned(nz2_s6));
			ql_s7   <= srt_pkg::QL_W'(vrnz_s6) - nysh_c;
			qr_s7   <= srt_pkg::QL_W'(vlnz_s6) - nysh_c;
		end
	end

	// Stage 8: numerators to sign and magnitude.
	srt_pkg::srt_side_t side_s8;
	srt_pkg::srt_side_t side8_c;
	logic [srt_pkg::DEN_W-1:0] den_s8;
	logic [srt_pkg::QM_W-1:0]  qml_s8, qmr_s8;
	logic v_s8;

	always_comb begin
		side8_c       = side_s7;
		side8_c.neg_l = ql_s7[srt_pkg::QL_W-1];
		side8_c.neg_r = qr_s7[srt_pkg::QL_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= side8_c;
			den_s8  <= den_s7;
			qml_s8  <= srt_pkg::QM_W'(ql_s7[srt_pkg::QL_W-1] ? -ql_s7 : ql_s7);
			qmr_s8  <= srt_pkg::QM_W'(qr_s7[srt_pkg::QL_W-1] ? -qr_s7 : qr_s7);
		end
	end

	// Stage 9: baseline times the numerator magnitudes, in two halves.
	srt_pkg::srt_side_t side_s9;
	logic [srt_pkg::DEN_W-1:0]                den_s9;
	logic [srt_pkg::BASE_W+srt_pkg::QLO_W-1:0] plo_l_s9, plo_r_s9;
	logic [srt_pkg::BASE_W+srt_pkg::QHI_W-1:0] phi_l_s9, phi_r_s9;
	logic v_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9  <= side_s8;
			den_s9   <= den_s8;
			plo_l_s9 <= base_q * qml_s8[srt_pkg::QLO_W-1:0];
			plo_r_s9 <= base_q * qmr_s8[srt_pkg::QLO_W-1:0];
			phi_l_s9 <= base_q * qml_s8[srt_pkg::QM_W-1:srt_pkg::QLO_W];
			phi_r_s9 <= base_q * qmr_s8[srt_pkg::QM_W-1:srt_pkg::QLO_W];
		end
	end

	// Stage 10: join the halves and flag parallel rays.
	srt_pkg::srt_side_t side_s10;
	srt_pkg::srt_side_t side10_c;
	logic [srt_pkg::DEN_W-1:0] den_s10;
	logic [srt_pkg::NUM_W-1:0] num_l_s10, num_r_s10;
	logic v_s10;

	always_comb begin
		side10_c     = side_s9;
		side10_c.par = den_s9 == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s10  <= side10_c;
			den_s10   <= den_s9;
			num_l_s10 <= (srt_pkg::NUM_W'(phi_l_s9) << srt_pkg::QLO_W) + srt_pkg::NUM_W'(plo_l_s9);
			num_r_s10 <= (srt_pkg::NUM_W'(phi_r_s9) << srt_pkg::QLO_W) + srt_pkg::NUM_W'(plo_r_s9);
		end
	end

	// Depth divider.
	logic                      vq;
	logic [srt_pkg::NUM_W-1:0] q_l, q_r;
	srt_pkg::srt_side_t        side_q;

	srt_zdiv u_zdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.num_l     (num_l_s10),
		.num_r     (num_r_s10),
		.den       (den_s10),
		.side_i    (side_s10),
		.out_valid (vq),
		.q_l       (q_l),
		.q_r       (q_r),
		.side_o    (side_q)
	);

	// Stage 11: clip depths and restore their signs.
	localparam logic [srt_pkg::NUM_W-1:0] ZLIM = srt_pkg::NUM_W'(1) << srt_pkg::DEPTH_SH;

	srt_pkg::srt_side_t side_s11;
	srt_pkg::srt_side_t side11_c;
	logic signed [srt_pkg::Z_W-1:0]   zl_s11, zr_s11;
	logic                             big_l, big_r;
	logic [srt_pkg::DEPTH_SH:0]       zml_c, zmr_c;
	logic v_s11;

	assign big_l = q_l > ZLIM;
	assign big_r = q_r > ZLIM;
	assign zml_c = big_l ? ZLIM[srt_pkg::DEPTH_SH:0] : q_l[srt_pkg::DEPTH_SH:0];
	assign zmr_c = big_r ? ZLIM[srt_pkg::DEPTH_SH:0] : q_r[srt_pkg::DEPTH_SH:0];

	always_comb begin
		side11_c     = side_q;
		side11_c.hit = side_q.hit | big_l | big_r;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s11 <= side11_c;
			zl_s11   <= side_q.neg_l ? -srt_pkg::Z_W'(zml_c) : srt_pkg::Z_W'(zml_c);
			zr_s11   <= side_q.neg_r ? -srt_pkg::Z_W'(zmr_c) : srt_pkg::Z_W'(zmr_c);
		end
	end

	// Stage 12: direction times depth as partial products on split depths.
	srt_pkg::srt_side_t side_s12;
	logic signed [srt_pkg::PLO_W-1:0] xll_s12, xrl_s12, yll_s12, yrl_s12;
	logic signed [srt_pkg::PHI_W-1:0] xlh_s12, xrh_s12, ylh_s12, yrh_s12;
	logic signed [srt_pkg::Z_W:0]     zs_s12;
	logic signed [srt_pkg::ZLO_W:0]   zllo_c, zrlo_c;
	logic signed [srt_pkg::ZHI_W-1:0] zlhi_c, zrhi_c;
	logic v_s12;

	assign zllo_c = $signed({1'b0, zl_s11[srt_pkg::ZLO_W-1:0]});
	assign zrlo_c = $signed({1'b0, zr_s11[srt_pkg::ZLO_W-1:0]});
	assign zlhi_c = zl_s11[srt_pkg::Z_W-1:srt_pkg::ZLO_W];
	assign zrhi_c = zr_s11[srt_pkg::Z_W-1:srt_pkg::ZLO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s12 <= side_s11;
			xll_s12  <= side_s11.ul * zllo_c;
			xrl_s12  <= side_s11.ur * zrlo_c;
			yll_s12  <= side_s11.vl * zllo_c;
			yrl_s12  <= side_s11.vr * zrlo_c;
			xlh_s12  <= side_s11.ul * zlhi_c;
			xrh_s12  <= side_s11.ur * zrhi_c;
			ylh_s12  <= side_s11.vl * zlhi_c;
			yrh_s12  <= side_s11.vr * zrhi_c;
			zs_s12   <= srt_pkg::Z_W'(zl_s11) + srt_pkg::Z_W'(zr_s11);
		end
	end

	// Stage 13: sum the partial products of both rays.
	srt_pkg::srt_side_t side_s13;
	logic signed [srt_pkg::M_W-1:0] sx_s13, sy_s13;
	logic signed [srt_pkg::Z_W:0]   zs_s13;
	logic v_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s13 <= side_s12;
			zs_s13   <= zs_s12;
			sx_s13 <= (srt_pkg::M_W'(xlh_s12) <<< srt_pkg::ZLO_W) + srt_pkg::M_W'(xll_s12)
				+ (srt_pkg::M_W'(xrh_s12) <<< srt_pkg::ZLO_W) + srt_pkg::M_W'(xrl_s12);
			sy_s13 <= (srt_pkg::M_W'(ylh_s12) <<< srt_pkg::ZLO_W) + srt_pkg::M_W'(yll_s12)
				+ (srt_pkg::M_W'(yrh_s12) <<< srt_pkg::ZLO_W) + srt_pkg::M_W'(yrl_s12);
		end
	end

	// Stage 14: scale down with truncation toward zero.
	srt_pkg::srt_side_t side_s14;
	logic signed [srt_pkg::MID_W-1:0] mx_s14, my_s14, mz_s14;
	logic signed [srt_pkg::M_W-1:0]   sxsh_c, sysh_c;
	logic signed [srt_pkg::Z_W:0]     zsh_c;
	logic                             rx_c, ry_c, rz_c;
	logic v_s14;

	assign sxsh_c = sx_s13 >>> srt_pkg::MID_SH;
	assign sysh_c = sy_s13 >>> srt_pkg::MID_SH;
	assign zsh_c  = zs_s13 >>> 1;
	assign rx_c   = sx_s13[srt_pkg::M_W-1] && (sx_s13[srt_pkg::MID_SH-1:0] != '0);
	assign ry_c   = sy_s13[srt_pkg::M_W-1] && (sy_s13[srt_pkg::MID_SH-1:0] != '0);
	assign rz_c   = zs_s13[srt_pkg::Z_W] && zs_s13[0];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s14 <= side_s13;
			mx_s14   <= srt_pkg::MID_W'(sxsh_c) + srt_pkg::MID_W'(rx_c);
			my_s14   <= srt_pkg::MID_W'(sysh_c) + srt_pkg::MID_W'(ry_c);
			mz_s14   <= srt_pkg::MID_W'(zsh_c) + srt_pkg::MID_W'(rz_c);
		end
	end

	// Stage 15: saturate to the output width; this is the output register.
	localparam logic signed [srt_pkg::MID_W-1:0] SAT_HI =
		srt_pkg::MID_W'((64'sd1 <<< (srt_pkg::COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [srt_pkg::MID_W-1:0] SAT_LO = -SAT_HI - srt_pkg::MID_W'(1);

	logic signed [srt_pkg::MID_W-1:0] cx_c, cy_c, cz_c;
	logic                             cl_c;

	always_comb begin
		cx_c = mx_s14;
		cy_c = my_s14;
		cz_c = mz_s14;
		cl_c = 1'b0;
		if (mx_s14 > SAT_HI) begin cx_c = SAT_HI; cl_c = 1'b1; end
		if (mx_s14 < SAT_LO) begin cx_c = SAT_LO; cl_c = 1'b1; end
		if (my_s14 > SAT_HI) begin cy_c = SAT_HI; cl_c = 1'b1; end
		if (my_s14 < SAT_LO) begin cy_c = SAT_LO; cl_c = 1'b1; end
		if (mz_s14 > SAT_HI) begin cz_c = SAT_HI; cl_c = 1'b1; end
		if (mz_s14 < SAT_LO) begin cz_c = SAT_LO; cl_c = 1'b1; end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid.mid_x         <= side_s14.par ? '0 : srt_pkg::COORD_BITS'(cx_c);
			mid.mid_y         <= side_s14.par ? '0 : srt_pkg::COORD_BITS'(cy_c);
			mid.mid_z         <= side_s14.par ? '0 : srt_pkg::COORD_BITS'(cz_c);
			mid.rays_parallel <= side_s14.par;
			mid.saturated     <= !side_s14.par && (side_s14.hit || cl_c);
		end
	end

	// Valid bits of the stages outside the two divider bit pipelines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			vd_sd[0] <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			v_s10    <= 1'b0;
			v_s11    <= 1'b0;
			v_s12    <= 1'b0;
			v_s13    <= 1'b0;
			v_s14    <= 1'b0;
			v_s15    <= 1'b0;
		end else if (en) begin
			v_s1     <= pix.valid;
			vd_sd[0] <= v_s1;
			v_s3     <= vd_sd[FD];
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			v_s9     <= v_s8;
			v_s10    <= v_s9;
			v_s11    <= vq;
			v_s12    <= v_s11;
			v_s13    <= v_s12;
			v_s14    <= v_s13;
			v_s15    <= v_s14;
		end
	end

	// Valid bits of the direction divider stages.
	for (genvar k = 0; k < FD; k++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_sd[k+1] <= 1'b0;
			end else if (en) begin
				vd_sd[k+1] <= vd_sd[k];
			end
		end
	end

	assign mid.valid = v_s15;

endmodule

@@ rtl/srt_chk.sv @@
// Port-level checker for the stereo triangulation block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srt_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  pix_ready,
	input logic                                  mid_valid,
	input logic                                  mid_ready,
	input logic signed [srt_pkg::COORD_BITS-1:0] mid_x,
	input logic signed [srt_pkg::COORD_BITS-1:0] mid_y,
	input logic signed [srt_pkg::COORD_BITS-1:0] mid_z,
	input logic                                  rays_parallel,
	input logic                                  saturated
);

	// A stalled result beat keeps its coordinates.
	`SRT_ASSERT(a_out_hold, clk, arst_n, mid_valid && !mid_ready |=> mid_valid && $stable(mid_x) && $stable(mid_y) && $stable(mid_z))

	// A stalled result beat keeps its flags.
	`SRT_ASSERT(a_flag_hold, clk, arst_n, mid_valid && !mid_ready |=> $stable(rays_parallel) && $stable(saturated))

	// Parallel rays give the origin and never report clipping.
	`SRT_IMPLIES(a_par_zero, clk, arst_n, mid_valid && rays_parallel, mid_x == 0 && mid_y == 0 && mid_z == 0 && !saturated)

	// With the output empty the block takes input.
	`SRT_IMPLIES(a_rdy_free, clk, arst_n, !mid_valid, pix_ready)

	// Input is refused only behind a stalled result.
	`SRT_IMPLIES(a_rdy_stall, clk, arst_n, !pix_ready, mid_valid && !mid_ready)

endmodule

bind stereo_ray_triangulation_top srt_chk u_srt_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.pix_ready     (pix.ready),
	.mid_valid     (mid.valid),
	.mid_ready     (mid.ready),
	.mid_x         (mid.mid_x),
	.mid_y         (mid.mid_y),
	.mid_z         (mid.mid_z),
	.rays_parallel (mid.rays_parallel),
	.saturated     (mid.saturated)
);
